@@ rtl/core/clbs_pkg.sv @@
`timescale 1ns / 1ps

package clbs_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned LANE_W = 8;
  localparam int unsigned EXCESS_W = 63;
  localparam int unsigned CHUNKS_W = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [3:0] DIST_NONE = 4'd8;
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [15:0] CHUNK_BITS_RST = 16'd2048;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CONTEXT_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BITS = 8'd1;

  // Context selection codes.
  typedef enum logic [3:0] {
    CTX_SINGLE     = 4'd0,
    CTX_POS8       = 4'd1,
    CTX_POS16      = 4'd2,
    CTX_POS32      = 4'd3,
    CTX_POS64      = 4'd4,
    CTX_PREV_BYTE  = 4'd5,
    CTX_PREV_POP   = 4'd6,
    CTX_PREV_HIGH  = 4'd7,
    CTX_BACK1      = 4'd8,
    CTX_BACK3      = 4'd9,
    CTX_BACK6      = 4'd10,
    CTX_J_BACK1    = 4'd11,
    CTX_J_POP      = 4'd12,
    CTX_DIST_FF    = 4'd13,
    CTX_DIST_ZERO  = 4'd14,
    CTX_J_HIGH3    = 4'd15
  } ctx_mode_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic sq;
    logic acc;
    logic next_bit;
    logic end_byte;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic bit_last;
    logic last;
    logic out_free;
  } sts_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int s = 0; s < 8; s++) begin
      c = c + {3'd0, v[s]};
    end
    return c;
  endfunction

  function automatic logic [LANE_W-1:0] lane_of(
    input logic [3:0] mode,
    input logic [2:0] phase,
    input logic [2:0] j,
    input logic [7:0] prev,
    input logic [7:0] cur,
    input logic [3:0] dff,
    input logic [3:0] dzz
  );
    logic [5:0] pos;
    logic [15:0] back;
    logic [7:0] jx;
    logic [7:0] lane;
    pos = {phase, j};
    back = {prev, cur} >> (5'd8 - {2'd0, j});
    jx = {5'd0, j};
    case (ctx_mode_e'(mode))
      CTX_SINGLE:    lane = 8'd0;
      CTX_POS8:      lane = {5'd0, pos[2:0]};
      CTX_POS16:     lane = {4'd0, pos[3:0]};
      CTX_POS32:     lane = {3'd0, pos[4:0]};
      CTX_POS64:     lane = {2'd0, pos};
      CTX_PREV_BYTE: lane = prev;
      CTX_PREV_POP:  lane = {4'd0, popcount8(prev)};
      CTX_PREV_HIGH: lane = {4'd0, prev[7:4]};
      CTX_BACK1:     lane = {7'd0, back[0]};
      CTX_BACK3:     lane = {5'd0, back[2:0]};
      CTX_BACK6:     lane = {2'd0, back[5:0]};
      CTX_J_BACK1:   lane = {jx[6:0], back[0]};
      CTX_J_POP:     lane = jx * 8'd9 + {4'd0, popcount8(prev)};
      CTX_DIST_FF:   lane = {1'b0, dff, j};
      CTX_DIST_ZERO: lane = {1'b0, dzz, j};
      CTX_J_HIGH3:   lane = {2'd0, prev[7:5], j};
      default:       lane = 8'd0;
    endcase
    return lane;
  endfunction

endpackage

@@ rtl/core/clbs_ctrl.sv @@
`timescale 1ns / 1ps

module clbs_ctrl
  import clbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_SQUARE = 6'b001000,
    S_ACCUM  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.wr = 1'b1;
        if (sts.hit) begin
          state_nxt = S_SQUARE;
        end else if (sts.bit_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.next_bit = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_SQUARE: begin
        cmd.sq = 1'b1;
        state_nxt = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.acc = 1'b1;
        if (sts.bit_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.next_bit = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_FINISH: begin
        // A final byte waits here until the result register can take it.
        if (!sts.last || sts.out_free) begin
          cmd.end_byte = 1'b1;
          cmd.emit = sts.last;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/clbs_datapath.sv @@
`timescale 1ns / 1ps

module clbs_datapath
  import clbs_pkg::*;
#(
  parameter int unsigned MAX_LANES = 256,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [DATA_W-1:0]     in_data,
  input  logic                  in_last,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [EXCESS_W-1:0]   out_excess,
  output logic [CHUNKS_W-1:0]   out_chunks
);

  localparam int unsigned LW = $clog2(MAX_LANES);
  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned NW = CW + 1;
  localparam int unsigned SQW = 2 * CW + 2;
  localparam int unsigned DW = SQW + 1;
  localparam int unsigned SW = ((DW > EXCESS_W) ? DW : EXCESS_W) + 1;
  localparam logic signed [SW-1:0] EX_MAX = {{(SW - 62){1'b0}}, {62{1'b1}}};
  localparam logic signed [SW-1:0] EX_MIN = {{(SW - 62){1'b1}}, {62{1'b0}}};

  logic [3:0] mode_r;
  logic [CFG_DATA_W-1:0] chunk_bits_r;
  logic [7:0] cur_r, prev_r;
  logic last_r;
  logic [2:0] bit_r, phase_r;
  logic [3:0] dff_r, dzz_r;

  logic [2*CW-1:0] mem [MAX_LANES];
  logic [MAX_LANES-1:0] valid_r;
  logic [2*CW-1:0] rd_data_r;
  logic rd_valid_r;
  logic [LW-1:0] lane_r;

  logic [NW-1:0] n_r;
  logic [CW-1:0] k_r;
  logic [SQW-1:0] sq_r;
  logic signed [EXCESS_W-1:0] excess_r;
  logic [CHUNKS_W-1:0] chunk_r;
  logic out_valid_r;
  logic [EXCESS_W-1:0] out_excess_r;
  logic [CHUNKS_W-1:0] out_chunks_r;

  logic [CW-1:0] target;
  logic [NW-1:0] n_val;
  logic [LW-1:0] lane_idx;
  logic [CW-1:0] old_cnt, old_zer, cnt_nxt, zer_nxt;
  logic cur_bit;
  logic signed [CW+2:0] diff;
  logic [NW-1:0] mag;
  logic signed [DW-1:0] delta;
  logic signed [SW-1:0] sum;
  logic signed [EXCESS_W-1:0] excess_nxt;
  logic [3:0] dff_nxt, dzz_nxt;

  assign target = CW'(chunk_bits_r);
  assign n_val = (target == '0) ? {1'b1, {CW{1'b0}}} : {1'b0, target};
  assign lane_idx = LW'(lane_of(mode_r, phase_r, bit_r, prev_r, cur_r, dff_r, dzz_r));

  assign old_cnt = rd_valid_r ? rd_data_r[CW-1:0] : '0;
  assign old_zer = rd_valid_r ? rd_data_r[2*CW-1:CW] : '0;
  assign cur_bit = cur_r[3'd7 - bit_r];
  assign cnt_nxt = old_cnt + CW'(1);
  assign zer_nxt = old_zer + CW'(!cur_bit);

  assign diff = $signed({2'b00, n_r}) - $signed({2'b00, k_r, 1'b0});
  assign mag = diff[CW+2] ? NW'(-diff) : NW'(diff);
  assign delta = $signed({1'b0, sq_r}) - $signed(DW'(n_r));
  assign sum = SW'(excess_r) + SW'(delta);
  assign excess_nxt = (sum > EX_MAX) ? EXCESS_W'(EX_MAX) :
                      (sum < EX_MIN) ? EXCESS_W'(EX_MIN) : EXCESS_W'(sum);

  assign dff_nxt = (cur_r == BYTE_ONES) ? 4'd0 :
                   (dff_r >= DIST_NONE) ? DIST_NONE : dff_r + 4'd1;
  assign dzz_nxt = (cur_r == BYTE_ZERO) ? 4'd0 :
                   (dzz_r >= DIST_NONE) ? DIST_NONE : dzz_r + 4'd1;

  assign sts.hit = (cnt_nxt == target);
  assign sts.bit_last = (bit_r == 3'd7);
  assign sts.last = last_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_excess = out_excess_r;
  assign out_chunks = out_chunks_r;

  // Lane counter memory: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[lane_idx];
    end
    if (cmd.wr) begin
      mem[lane_r] <= sts.hit ? '0 : {zer_nxt, cnt_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r <= in_data;
    end
    if (cmd.rd) begin
      lane_r <= lane_idx;
    end
    if (cmd.wr) begin
      n_r <= n_val;
      k_r <= zer_nxt;
    end
    if (cmd.sq) begin
      sq_r <= SQW'(mag) * SQW'(mag);
    end
    if (cmd.emit) begin
      out_excess_r <= excess_r;
      out_chunks_r <= chunk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 4'd0;
      chunk_bits_r <= CHUNK_BITS_RST;
      last_r <= 1'b0;
      bit_r <= 3'd0;
      valid_r <= '0;
      rd_valid_r <= 1'b0;
      prev_r <= 8'd0;
      phase_r <= 3'd0;
      dff_r <= DIST_NONE;
      dzz_r <= DIST_NONE;
      excess_r <= '0;
      chunk_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == REG_CONTEXT_MODE) begin
        mode_r <= cfg_data[3:0];
      end
      if (cfg_valid && cfg_index == REG_CHUNK_BITS) begin
        chunk_bits_r <= cfg_data;
      end
      if (cmd.load) begin
        last_r <= in_last;
        bit_r <= 3'd0;
      end
      if (cmd.next_bit) begin
        bit_r <= bit_r + 3'd1;
      end
      if (cmd.rd) begin
        rd_valid_r <= valid_r[lane_idx];
      end
      if (cmd.wr) begin
        valid_r[lane_r] <= 1'b1;
      end
      if (cmd.acc) begin
        excess_r <= excess_nxt;
        if (chunk_r != {CHUNKS_W{1'b1}}) begin
          chunk_r <= chunk_r + CHUNKS_W'(1);
        end
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        valid_r <= '0;
        prev_r <= 8'd0;
        phase_r <= 3'd0;
        dff_r <= DIST_NONE;
        dzz_r <= DIST_NONE;
        excess_r <= '0;
        chunk_r <= '0;
      end else if (cmd.end_byte) begin
        prev_r <= cur_r;
        phase_r <= phase_r + 3'd1;
        dff_r <= dff_nxt;
        dzz_r <= dzz_nxt;
      end
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result emitted over an untaken result");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (excess_r == '0 && chunk_r == '0 && valid_r == '0))
    else $error("state not cleared after final byte");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> $past(cmd.rd))
    else $error("lane write without preceding read");

endmodule

@@ rtl/core/context_lane_bias_scanner.sv @@
`timescale 1ns / 1ps

// Context lane bias scanner. Each input beat carries one byte, whose eight
// bits are handled most significant bit first; the selected context maps each
// bit to a lane with its own bit and zero counters. When a lane fills a chunk
// of n bits with k zeros, (n-2k)^2-n is added to a saturating signed sum and
// the chunk count rises. The beat with tlast set is processed, then one result
// beat carries the sum and chunk count and all scan state is cleared, with no
// clearing pass. A byte is accepted in idle, then each bit is read and
// updated, plus a square and an accumulate step per chunk completed, and a
// wrap-up step ends the byte before the next is taken. The read and update
// split comes from the lane counter memory, with registered read data. A
// finished result sits in an output register, so the next byte is accepted
// while it waits; only a second final byte stalls until it is taken.
// Configuration writes are accepted every cycle and belong only in idle time.

module context_lane_bias_scanner
  import clbs_pkg::*;
#(
  parameter int unsigned MAX_LANES = 256,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [95:0]           out_tdata,  // [62:0] excess_sum, [94:63] chunk_total, [95] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic [EXCESS_W-1:0] excess;
  logic [CHUNKS_W-1:0] chunks;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;
  assign out_tdata = {1'b0, chunks, excess};

  clbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  clbs_datapath #(
    .MAX_LANES   (MAX_LANES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_tdata),
    .in_last    (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_excess (excess),
    .out_chunks (chunks)
  );

endmodule

@@ dv/context_lane_bias_scanner_test.sv @@
`timescale 1ns / 1ps

// Bench for the context lane bias scanner. A byte-level model of the scanner
// runs beside the block and predicts every result beat from the accepted
// bytes. Results are checked in order, field by field.
module context_lane_bias_scanner_test;
  import clbs_pkg::*;

  localparam longint SUM_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  // A few idle cycles between phases once the block is back in idle.
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  typedef struct {
    logic [62:0] excess;
    logic [31:0] chunks;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  context_lane_bias_scanner i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Bytes waiting to be sent and results waiting to be seen.
  byte_beat_t byte_backlog[$];
  scan_result_t expected_scans[$];

  // Shadow of the configuration registers and the scan state.
  ctx_mode_e shadow_mode = CTX_SINGLE;
  logic [15:0] shadow_chunk_len = CHUNK_BITS_RST;
  logic [15:0] lane_bits[256];
  logic [15:0] lane_zeros[256];
  logic [7:0] last_seen_byte;
  logic [2:0] byte_slot;
  logic [3:0] dist_since_ff;
  logic [3:0] dist_since_zero;
  longint excess_sum;
  logic [31:0] chunk_count;

  int error_count = 0;
  int bytes_scanned = 0;
  int scans_checked = 0;
  int chunks_seen = 0;
  bit idling_on = 1'b1;
  int send_gap = 0;
  int take_gap = 0;
  bit [15:0] modes_used = '0;

  task automatic clear_scan();
    for (int l = 0; l < 256; l++) begin
      lane_bits[l] = '0;
      lane_zeros[l] = '0;
    end
    last_seen_byte = BYTE_ZERO;
    byte_slot = '0;
    dist_since_ff = DIST_NONE;
    dist_since_zero = DIST_NONE;
    excess_sum = 0;
    chunk_count = '0;
  endtask

  initial clear_scan();

  // Lane that bit j of the current byte lands in under the active context.
  function automatic int unsigned lane_for_bit(logic [7:0] cur, int unsigned j);
    logic [15:0] history;
    int unsigned pos;
    int unsigned pop;
    history = {last_seen_byte, cur} >> (8 - j);
    pos = {byte_slot, 3'(j)};
    pop = $countones(last_seen_byte);
    case (shadow_mode)
      CTX_SINGLE:    return 0;
      CTX_POS8:      return pos % 8;
      CTX_POS16:     return pos % 16;
      CTX_POS32:     return pos % 32;
      CTX_POS64:     return pos % 64;
      CTX_PREV_BYTE: return last_seen_byte;
      CTX_PREV_POP:  return pop;
      CTX_PREV_HIGH: return last_seen_byte[7:4];
      CTX_BACK1:     return history[0];
      CTX_BACK3:     return history[2:0];
      CTX_BACK6:     return history[5:0];
      CTX_J_BACK1:   return j * 2 + history[0];
      CTX_J_POP:     return j * 9 + pop;
      CTX_DIST_FF:   return dist_since_ff * 8 + j;
      CTX_DIST_ZERO: return dist_since_zero * 8 + j;
      default:       return last_seen_byte[7:5] * 8 + j;
    endcase
  endfunction

  // Fold one full chunk of n bits with k zeros into the saturating sum.
  task automatic tally_chunk(longint n, longint k);
    longint d;
    longint sq;
    d = n - 2 * k;
    sq = d * d;
    if (sq >= n) begin
      if (sq - n > SUM_MAX - excess_sum) excess_sum = SUM_MAX;
      else excess_sum += sq - n;
    end else begin
      if (n - sq > excess_sum - SUM_MIN) excess_sum = SUM_MIN;
      else excess_sum -= n - sq;
    end
    if (chunk_count != '1) chunk_count++;
    chunks_seen++;
  endtask

  // Advance the shadow scan by one accepted byte.
  task automatic scan_byte(logic [7:0] cur, logic last);
    int unsigned lane;
    logic [15:0] cnt;
    logic [15:0] zer;
    scan_result_t res;
    for (int unsigned j = 0; j < 8; j++) begin
      lane = lane_for_bit(cur, j);
      cnt = lane_bits[lane] + 16'd1;
      zer = lane_zeros[lane] + {15'd0, ~cur[7-j]};
      if (cnt == shadow_chunk_len) begin
        // A length of zero stands for the full counter range.
        tally_chunk((shadow_chunk_len == 0) ? 65536 : shadow_chunk_len, zer);
        cnt = '0;
        zer = '0;
      end
      lane_bits[lane] = cnt;
      lane_zeros[lane] = zer;
    end
    dist_since_ff = (cur == BYTE_ONES) ? 4'd0 :
                    (dist_since_ff >= DIST_NONE) ? DIST_NONE : dist_since_ff + 4'd1;
    dist_since_zero = (cur == BYTE_ZERO) ? 4'd0 :
                      (dist_since_zero >= DIST_NONE) ? DIST_NONE : dist_since_zero + 4'd1;
    last_seen_byte = cur;
    byte_slot = byte_slot + 3'd1;
    bytes_scanned++;
    if (last) begin
      res.excess = excess_sum[62:0];
      res.chunks = chunk_count;
      expected_scans.push_back(res);
      clear_scan();
    end
  endtask

  // Byte driver. A byte is folded into the shadow scan on the edge it is
  // accepted, then the next one is offered unless an idle burst is due.
  always @(posedge clk) begin
    byte_beat_t b;
    if (rst_n) begin
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (byte_backlog.size() > 0) begin
          b = byte_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= b.data;
          in_tlast <= b.last;
          if (idling_on && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor, with random back-pressure bursts.
  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_scans.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, out_tdata);
          error_count++;
        end else begin
          want = expected_scans.pop_front();
          scans_checked++;
          if (out_tdata[62:0] !== want.excess) begin
            $display("%0t: excess_sum expected %0d got %0d", $time,
                     $signed(want.excess), $signed(out_tdata[62:0]));
            error_count++;
          end
          if (out_tdata[94:63] !== want.chunks) begin
            $display("%0t: chunk_total expected %0d got %0d", $time,
                     want.chunks, out_tdata[94:63]);
            error_count++;
          end
          if (out_tdata[95] !== 1'b0) begin
            $display("%0t: pad bit expected 0 got %b", $time, out_tdata[95]);
            error_count++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idling_on && $urandom_range(0, 5) == 0) take_gap <= $urandom_range(1, 10);
      end
    end
  end

  // Wait until every byte is in, every result is out and the block is back
  // in idle. Sampling at the falling edge sees the settled handshake.
  task automatic wait_quiet();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || in_tvalid || !in_tready ||
           expected_scans.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CONTEXT_MODE) begin
      shadow_mode = ctx_mode_e'(value[3:0]);
      modes_used[value[3:0]] = 1'b1;
    end else if (idx == REG_CHUNK_BITS) begin
      shadow_chunk_len = value;
    end
  endtask

  // Upper data bits are random so that the block must mask them.
  task automatic set_mode(ctx_mode_e m);
    write_reg(REG_CONTEXT_MODE, {12'($urandom), m});
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return BYTE_ZERO;
      1: return BYTE_ONES;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_bytes(int count, bit close);
    byte_beat_t b;
    for (int i = 0; i < count; i++) begin
      b.data = pick_byte();
      b.last = close && (i == count - 1);
      byte_backlog.push_back(b);
    end
  endtask

  task automatic queue_byte(logic [7:0] data, logic last);
    byte_beat_t b;
    b.data = data;
    b.last = last;
    byte_backlog.push_back(b);
  endtask

  initial begin
    int sent;
    int len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: long chunks, so nothing completes and the sum is zero.
    queue_byte(BYTE_ZERO, 1'b0);
    queue_byte(BYTE_ONES, 1'b0);
    queue_byte(8'hA5, 1'b1);
    queue_byte(8'h3C, 1'b1);  // a frame of a single byte
    wait_quiet();

    // Shortest meaningful chunk and the degenerate length of one, with
    // all-zero and all-one bytes for the extreme sums.
    set_mode(CTX_SINGLE);
    write_reg(REG_CHUNK_BITS, 16'd2);
    queue_byte(BYTE_ZERO, 1'b0);
    queue_byte(BYTE_ONES, 1'b0);
    queue_byte(8'h55, 1'b1);
    wait_quiet();
    write_reg(REG_CHUNK_BITS, 16'd1);
    queue_byte(8'h96, 1'b1);
    wait_quiet();
    write_reg(REG_CHUNK_BITS, 16'hFFFF);
    set_mode(CTX_J_HIGH3);
    queue_bytes(4, 1'b1);
    wait_quiet();

    // An index past the register map must change nothing.
    write_reg(8'($urandom_range(REG_CHUNK_BITS + 1, 255)), 16'($urandom));
    write_reg(8'hFF, 16'($urandom));

    // Every context once with chunks of eight bits; an FF byte leads, 00 and FF mixed in.
    write_reg(REG_CHUNK_BITS, 16'd8);
    for (int m = 0; m < 16; m++) begin
      set_mode(ctx_mode_e'(m));
      queue_byte(BYTE_ONES, 1'b0);
      queue_bytes(6, 1'b1);
      wait_quiet();
    end

    // Chunk length of zero: one chunk spans the full counter range, so a
    // short frame completes none.
    set_mode(CTX_SINGLE);
    write_reg(REG_CHUNK_BITS, 16'd0);
    queue_bytes(8, 1'b1);
    wait_quiet();

    // Change the chunk length in the middle of a frame: the counts built up
    // so far carry over to the new length.
    write_reg(REG_CHUNK_BITS, 16'd64);
    queue_bytes(2, 1'b0);
    wait_quiet();
    write_reg(REG_CHUNK_BITS, 16'd24);
    queue_bytes(4, 1'b1);
    wait_quiet();

    // Random frames with random settings, sometimes reconfigured mid-frame.
    sent = 0;
    while (sent < 370) begin
      if (sent >= 290) idling_on = 1'b0;
      set_mode(ctx_mode_e'($urandom_range(0, 15)));
      case ($urandom_range(0, 19))
        0:       write_reg(REG_CHUNK_BITS, 16'd1);
        1:       write_reg(REG_CHUNK_BITS, 16'($urandom));
        default: write_reg(REG_CHUNK_BITS, 16'($urandom_range(2, 24)));
      endcase
      len = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) begin
        queue_bytes(len, 1'b0);
        wait_quiet();
        set_mode(ctx_mode_e'($urandom_range(0, 15)));
        write_reg(REG_CHUNK_BITS, 16'($urandom_range(2, 24)));
        sent += len;
        len = $urandom_range(1, 20);
      end
      queue_bytes(len, 1'b1);
      sent += len;
      wait_quiet();
    end

    $display("Scanned %0d bytes in %0d frames under %0d contexts, %0d chunks completed.",
             bytes_scanned, scans_checked, $countones(modes_used), chunks_seen);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding.", expected_scans.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
